// ===== design/mono_letterbox_scanout_assert.svh =====
// assertion macros for the letterbox scan-out block
// no dependencies; included by mono_letterbox_scanout.sv
`ifndef MONO_LETTERBOX_SCANOUT_ASSERT_SVH
`define MONO_LETTERBOX_SCANOUT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define MLS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define MLS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/mls_pkg.sv =====
// constants, register indexes and helpers for the letterbox scan-out block
// no dependencies; imported by mono_letterbox_scanout
package mls_pkg;

    localparam int DEF_FRAME_WIDTH  = 800;
    localparam int DEF_FRAME_HEIGHT = 600;

    localparam int REG_W     = 10;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SOURCE_WIDTH  = 2'd0,
        CFG_SOURCE_HEIGHT = 2'd1,
        CFG_INVERT_PIXELS = 2'd2
    } cfg_index_t;

    localparam logic [REG_W-1:0] RST_SOURCE_WIDTH  = 10'd512;
    localparam logic [REG_W-1:0] RST_SOURCE_HEIGHT = 10'd342;
    localparam logic             RST_INVERT_PIXELS = 1'b1;

    localparam logic [7:0] BYTE_ONES = 8'hFF;
    localparam logic [7:0] BYTE_ZERO = 8'h00;

    function automatic logic [7:0] mirror8(input logic [7:0] v);
        logic [7:0] r;
        for (int b = 0; b < 8; b++)
        begin
            r[b] = v[7-b];
        end
        return r;
    endfunction

endpackage

// ===== design/mono_letterbox_scanout.sv =====
// letterbox scan-out: one output byte per accepted transaction, two register stages
// out_valid follows the accepted transaction through the input and result stage registers
// throughput: one per cycle unless out_stall fills the pipe; one-pass compare and mirror
// reset: position counters go to line 0 column 0, registers to 512x342 inverted, pipe empty
// depends on mls_pkg and mono_letterbox_scanout_assert.svh
module mono_letterbox_scanout
    import mls_pkg::*;
#(
    parameter int FRAME_WIDTH  = DEF_FRAME_WIDTH,
    parameter int FRAME_HEIGHT = DEF_FRAME_HEIGHT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [REG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           src_byte,
    input  logic                 src_attached,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [7:0]           out_byte,
    output logic                 took_src,
    output logic                 line_last,
    output logic                 frame_last
);

    localparam int LINE_BYTES = FRAME_WIDTH / 8;
    localparam int COL_W      = $clog2(LINE_BYTES);
    localparam int ROW_W      = $clog2(FRAME_HEIGHT);
    localparam int WW = ($clog2(FRAME_WIDTH + 1) > REG_W) ? $clog2(FRAME_WIDTH + 1) : REG_W;
    localparam int HW = ($clog2(FRAME_HEIGHT + 1) > REG_W) ? $clog2(FRAME_HEIGHT + 1) : REG_W;

    localparam logic [COL_W-1:0] COL_LAST = COL_W'(LINE_BYTES - 1);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(FRAME_HEIGHT - 1);

    // configuration
    logic [REG_W-1:0] source_width_reg;
    logic [REG_W-1:0] source_height_reg;
    logic             invert_pixels_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_width_reg  <= RST_SOURCE_WIDTH;
            source_height_reg <= RST_SOURCE_HEIGHT;
            invert_pixels_reg <= RST_INVERT_PIXELS;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_SOURCE_WIDTH:  source_width_reg  <= cfg_data;
                CFG_SOURCE_HEIGHT: source_height_reg <= cfg_data;
                CFG_INVERT_PIXELS: invert_pixels_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // handshake
    logic a_valid_reg;
    logic b_valid_reg;
    logic b_ready;
    logic a_ready;
    logic in_accept;

    assign b_ready   = !b_valid_reg || !out_stall;
    assign a_ready   = !a_valid_reg || b_ready;
    assign in_stall  = !a_ready;
    assign in_accept = in_valid && a_ready;

    // position counters, advanced per accepted transaction
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    logic             eol;
    logic             eof;

    assign eol = (col_reg == COL_LAST);
    assign eof = eol && (row_reg == ROW_LAST);

    always_comb
    begin
        col_next = col_reg + COL_W'(1);
        row_next = row_reg;
        if (eol)
        begin
            col_next = '0;
            row_next = (row_reg == ROW_LAST) ? '0 : row_reg + ROW_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (in_accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // input stage
    logic [7:0]       a_src_reg;
    logic             a_att_reg;
    logic [COL_W-1:0] a_col_reg;
    logic [ROW_W-1:0] a_row_reg;
    logic             a_eol_reg;
    logic             a_eof_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (a_ready)
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            a_src_reg <= src_byte;
            a_att_reg <= src_attached;
            a_col_reg <= col_reg;
            a_row_reg <= row_reg;
            a_eol_reg <= eol;
            a_eof_reg <= eof;
        end
    end

    // window geometry from the live registers
    logic [WW-1:0] w_clamp;
    logic [HW-1:0] h_clamp;
    logic [WW-1:0] hoff;
    logic [WW-1:0] stride;
    logic [HW-1:0] voff;
    logic [WW-1:0] x_ext;
    logic [HW-1:0] y_ext;
    logic          in_window;
    logic [7:0]    pix;

    always_comb
    begin
        w_clamp = (WW'(source_width_reg) > WW'(FRAME_WIDTH)) ? WW'(FRAME_WIDTH)
                                                             : WW'(source_width_reg);
        h_clamp = (HW'(source_height_reg) > HW'(FRAME_HEIGHT)) ? HW'(FRAME_HEIGHT)
                                                               : HW'(source_height_reg);
        // half the margin, rounded down to a byte boundary
        hoff   = (WW'(FRAME_WIDTH) - w_clamp) >> 4;
        stride = w_clamp >> 3;
        voff   = (HW'(FRAME_HEIGHT) - h_clamp) >> 1;
        x_ext  = WW'(a_col_reg);
        y_ext  = HW'(a_row_reg);
        in_window = a_att_reg
                 && (y_ext >= voff) && (y_ext < voff + h_clamp)
                 && (x_ext >= hoff) && (x_ext < hoff + stride);
        pix = BYTE_ZERO;
        if (in_window)
        begin
            pix = mirror8(a_src_reg) ^ (invert_pixels_reg ? BYTE_ONES : BYTE_ZERO);
        end
    end

    // result stage
    logic [7:0] b_byte_reg;
    logic       b_took_reg;
    logic       b_eol_reg;
    logic       b_eof_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (b_ready)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_ready && a_valid_reg)
        begin
            b_byte_reg <= pix;
            b_took_reg <= in_window;
            b_eol_reg  <= a_eol_reg;
            b_eof_reg  <= a_eof_reg;
        end
    end

    assign out_valid  = b_valid_reg;
    assign out_byte   = b_byte_reg;
    assign took_src   = b_took_reg;
    assign line_last  = b_eol_reg;
    assign frame_last = b_eof_reg;

`include "mono_letterbox_scanout_assert.svh"

    `MLS_ASSERT_NOW(a_frame_has_line, clk, rst_n, out_valid && frame_last, line_last, "frame_last without line_last")
    `MLS_ASSERT_NOW(a_border_black, clk, rst_n, out_valid && !took_src, out_byte == BYTE_ZERO, "border byte not black")
    `MLS_ASSERT_NOW(a_stall_cause, clk, rst_n, in_stall, a_valid_reg && b_valid_reg && out_stall, "input stalled with room in the pipe")
    `MLS_ASSERT_NEXT(a_col_wrap, clk, rst_n, in_accept && (col_reg == COL_LAST), col_reg == '0, "column did not wrap at line end")

endmodule

// ===== sim/mono_letterbox_scanout_test.sv =====
`timescale 1ns / 100ps
// self-checking bench for mono_letterbox_scanout: a local raster predictor runs beside the dut
// directed corner bytes, then random phases over many window settings
// depends on mls_pkg and the design sources
module mono_letterbox_scanout_test;
    import mls_pkg::*;

    localparam int LINE_BYTES  = DEF_FRAME_WIDTH / 8;
    localparam int ITEM_TARGET = 800;

    typedef struct packed {
        logic [7:0] pix;
        logic       took;
        logic       eol;
        logic       eof;
    } scan_byte_t;

    typedef struct packed {
        logic [7:0] src;
        logic       attached;
    } src_item_t;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 cfg_write_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index    = '0;
    logic [REG_W-1:0]     cfg_data     = '0;
    logic                 in_valid     = 1'b0;
    logic                 in_stall;
    logic [7:0]           src_byte     = '0;
    logic                 src_attached = 1'b0;
    logic                 out_valid;
    logic                 out_stall    = 1'b0;
    logic [7:0]           out_byte;
    logic                 took_src;
    logic                 line_last;
    logic                 frame_last;

    src_item_t  pending_bytes[$];
    scan_byte_t expected_bytes[$];
    int         errors       = 0;
    int         items_queued = 0;
    int         cycle_count  = 0;

    // window registers and raster position as the predictor tracks them
    logic [REG_W-1:0] win_width  = RST_SOURCE_WIDTH;
    logic [REG_W-1:0] win_height = RST_SOURCE_HEIGHT;
    logic             win_invert = RST_INVERT_PIXELS;
    logic [6:0]       col_pos    = '0;
    logic [9:0]       line_pos   = '0;

    mono_letterbox_scanout dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .src_byte     (src_byte),
        .src_attached (src_attached),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_byte     (out_byte),
        .took_src     (took_src),
        .line_last    (line_last),
        .frame_last   (frame_last)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    function automatic logic quiet_stretch();
        return cycle_count >= 400 && cycle_count < 900;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        if (errors <= 40)
        begin
            $display("%0t mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        end
    endtask

    // one output byte from the current raster position, then advance it
    task automatic raster_step(input logic [7:0] src, input logic attached);
        int         w;
        int         h;
        int         top;
        int         left;
        int         stride;
        logic [7:0] pix;
        scan_byte_t r;
        w      = (win_width > DEF_FRAME_WIDTH) ? DEF_FRAME_WIDTH : int'(win_width);
        h      = (win_height > DEF_FRAME_HEIGHT) ? DEF_FRAME_HEIGHT : int'(win_height);
        top    = (DEF_FRAME_HEIGHT - h) / 2;
        left   = ((DEF_FRAME_WIDTH - w) / 2) / 8;
        stride = w / 8;
        r.took = attached && int'(line_pos) >= top && int'(line_pos) < top + h
                 && int'(col_pos) >= left && int'(col_pos) < left + stride;
        pix = {<<{src}};
        if (win_invert)
        begin
            pix = pix ^ BYTE_ONES;
        end
        r.pix = r.took ? pix : BYTE_ZERO;
        r.eol = int'(col_pos) == LINE_BYTES - 1;
        r.eof = r.eol && int'(line_pos) == DEF_FRAME_HEIGHT - 1;
        expected_bytes.push_back(r);
        if (r.eol)
        begin
            col_pos  = '0;
            line_pos = r.eof ? '0 : line_pos + 1'b1;
        end
        else
        begin
            col_pos = col_pos + 1'b1;
        end
    endtask

    // source side: present queued bytes, predict on each accepted transaction
    always @(posedge clk or negedge rst_n)
    begin : feed
        src_item_t nxt;
        if (!rst_n)
        begin
            in_valid     <= 1'b0;
            src_byte     <= '0;
            src_attached <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                raster_step(src_byte, src_attached);
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_bytes.size() != 0 && (quiet_stretch() || $urandom_range(99) >= 28))
                begin
                    nxt = pending_bytes.pop_front();
                    in_valid     <= 1'b1;
                    src_byte     <= nxt.src;
                    src_attached <= nxt.attached;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // sink side: random stalls, compare each accepted transaction with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin : sink
        scan_byte_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_bytes.size() == 0)
                begin
                    report_mismatch("unexpected transaction", out_byte, 0);
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (out_byte !== want.pix)
                        report_mismatch("out_byte", out_byte, want.pix);
                    if (took_src !== want.took)
                        report_mismatch("took_src", took_src, want.took);
                    if (line_last !== want.eol)
                        report_mismatch("line_last", line_last, want.eol);
                    if (frame_last !== want.eof)
                        report_mismatch("frame_last", frame_last, want.eof);
                end
            end
            out_stall <= !quiet_stretch() && $urandom_range(99) < 28;
        end
    end

    task automatic queue_byte(input logic [7:0] src, input logic attached);
        src_item_t it;
        it.src      = src;
        it.attached = attached;
        pending_bytes.push_back(it);
        items_queued++;
    endtask

    task automatic wait_idle();
        while (pending_bytes.size() != 0 || in_valid || expected_bytes.size() != 0)
        begin
            @(posedge clk);
        end
        // pipe is two stages deep, leave some margin
        repeat (6) @(posedge clk);
    endtask

    task automatic load_window(input logic [REG_W-1:0] w, input logic [REG_W-1:0] h,
                               input logic inv);
        wait_idle();
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= CFG_SOURCE_WIDTH;
        cfg_data     <= w;
        @(posedge clk);
        cfg_index    <= CFG_SOURCE_HEIGHT;
        cfg_data     <= h;
        @(posedge clk);
        cfg_index    <= CFG_INVERT_PIXELS;
        cfg_data     <= {{(REG_W-1){1'b0}}, inv};
        @(posedge clk);
        cfg_write_en <= 1'b0;
        win_width  = w;
        win_height = h;
        win_invert = inv;
    endtask

    task automatic random_bytes(input int n);
        for (int i = 0; i < n; i++)
        begin
            queue_byte(8'($urandom_range(255)), $urandom_range(9) != 0);
        end
    endtask

    initial
    begin
        logic [7:0]       corner_bytes[6];
        logic [REG_W-1:0] plan_w[6];
        logic [REG_W-1:0] plan_h[6];
        logic             plan_inv[6];
        int               plan_n[6];
        logic [REG_W-1:0] w;
        int               n;
        corner_bytes = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h5A, 8'hA5};
        // full window, width 8, width below 8, height 0, 512 by 598, clamped
        plan_w   = '{10'd800, 10'd8, 10'd7, 10'd640, 10'd512, 10'h3FF};
        plan_h   = '{10'd600, 10'd600, 10'd600, 10'd0, 10'd598, 10'h3FF};
        plan_inv = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
        plan_n   = '{150, 120, 80, 80, 150, 120};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // reset window puts line 0 in the top border
        queue_byte(8'hFF, 1'b1);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b0);

        // oversized registers clamp to the full frame
        load_window(10'h3FF, 10'h3FF, 1'b0);
        foreach (corner_bytes[i])
        begin
            queue_byte(corner_bytes[i], 1'b1);
            queue_byte(corner_bytes[i], 1'b0);
        end
        load_window(10'h3FF, 10'h3FF, 1'b1);
        foreach (corner_bytes[i])
        begin
            queue_byte(corner_bytes[i], 1'b1);
        end

        foreach (plan_n[i])
        begin
            load_window(plan_w[i], plan_h[i], plan_inv[i]);
            random_bytes(plan_n[i]);
        end

        // finish the run under a few random windows
        while (items_queued < ITEM_TARGET)
        begin
            if ($urandom_range(3) == 0)
                w = 10'($urandom_range(15));
            else
                w = 10'($urandom_range(1023));
            load_window(w, 10'($urandom_range(1023)), 1'($urandom_range(1)));
            n = ITEM_TARGET - items_queued;
            random_bytes(n > 40 ? 40 : n);
        end

        wait_idle();
        if (expected_bytes.size() != 0)
        begin
            report_mismatch("missing transactions", 0, expected_bytes.size());
        end
        if (errors == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
